// File: rtl/tcd_pkg.sv
// Shared types, register codes and constants of the tempo clock divider.
`default_nettype none

package tcd_pkg;

  // Field widths of the configuration registers.
  localparam int TEMPO_W    = 15;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TEMPO_W;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd1;

  // Clock source modes; any other code behaves as external gate.
  localparam logic [MODE_W-1:0] MODE_INTERNAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIDI     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GATE     = 2'd2;

  // Reset value of the tempo register, in hundredths of a beat per minute.
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 15'd12000;

  // Default parameter values.
  localparam int PULSES_PER_QUARTER_DEF = 96;
  localparam int CLOCK_DIVIDE_DEF       = 16;

  // Period arithmetic constants.
  localparam longint unsigned TICK_NUMER  = 120000000;
  localparam longint unsigned SEC_PER_MIN = 60;
  localparam int              BPM_SCALE   = 100;

  // Division by 100 as a multiply by 5243 and a shift right by 19; exact for
  // every 15-bit tempo value.
  localparam int BPM_RECIP       = 5243;
  localparam int BPM_RECIP_W     = 13;
  localparam int BPM_RECIP_SHIFT = 19;
  localparam int BPM_W           = 9;

  // Payload of one input item.
  typedef struct packed {
    logic [31:0] cycle_time;
    logic        playing;
    logic        midi_clock_level;
  } tcd_in_t;

  // Payload of one result item.
  typedef struct packed {
    logic clock_level;
    logic midi_clock_tick;
    logic ppq_pulse;
    logic load_permit;
  } tcd_out_t;

endpackage : tcd_pkg

`default_nettype wire

// File: rtl/tcd_period_div.sv
// Pulse period unit: derives the pulse period from the tempo with a bit-serial divider.
`default_nettype none

module tcd_period_div
  import tcd_pkg::*;
#(
  parameter int PULSES_PER_QUARTER = PULSES_PER_QUARTER_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [TEMPO_W-1:0]  tempo,
  output logic                     busy,
  output logic [31:0]              period
);

  // Dividend and its width; the quotient never exceeds it.
  localparam longint unsigned NUMER = TICK_NUMER / PULSES_PER_QUARTER;
  localparam int NW = $clog2(NUMER + 1);
  localparam int CW = $clog2(NW);
  localparam int MW = NW + 6;
  localparam int PW = TEMPO_W + BPM_RECIP_W;

  // Period for the reset tempo, saturated to 32 bits.
  localparam longint unsigned RST_FULL =
    (NUMER / (TEMPO_RESET / BPM_SCALE)) * SEC_PER_MIN;
  localparam logic [31:0] RST_PERIOD =
    (RST_FULL > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(RST_FULL);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BPM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_MUL  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [TEMPO_W-1:0] tempo_r, tempo_nxt;
  logic [BPM_W-1:0]   bpm_r, bpm_nxt;
  logic [BPM_W-1:0]   rem_r, rem_nxt;
  logic [NW-1:0]      quot_r, quot_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [31:0]        period_r, period_nxt;

  logic [PW-1:0]      bpm_prod;
  logic [BPM_W-1:0]   bpm_raw;
  logic [BPM_W:0]     rem_sh;
  logic               rem_ge;
  logic [MW-1:0]      mul_full;
  logic [63:0]        mul_ext;

  // Tempo divided by 100 through the reciprocal, then clamped to 1 BPM.
  assign bpm_prod = PW'(tempo_r) * PW'(BPM_RECIP);
  assign bpm_raw  = bpm_prod[BPM_RECIP_SHIFT +: BPM_W];

  // One restoring division step a cycle.
  assign rem_sh = {rem_r, quot_r[NW-1]};
  assign rem_ge = (rem_sh >= {1'b0, bpm_r});

  // Quotient scaled to seconds and saturated to 32 bits.
  assign mul_full = MW'(quot_r) * MW'(SEC_PER_MIN);
  assign mul_ext  = 64'(mul_full);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt  = state_r;
    tempo_nxt  = tempo_r;
    bpm_nxt    = bpm_r;
    rem_nxt    = rem_r;
    quot_nxt   = quot_r;
    cnt_nxt    = cnt_r;
    period_nxt = period_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          tempo_nxt = tempo;
          state_nxt = ST_BPM;
        end
      end
      ST_BPM: begin
        bpm_nxt   = (bpm_raw == '0) ? BPM_W'(1) : bpm_raw;
        rem_nxt   = '0;
        quot_nxt  = NW'(NUMER);
        cnt_nxt   = CW'(NW - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? BPM_W'(rem_sh - {1'b0, bpm_r}) : rem_sh[BPM_W-1:0];
        quot_nxt = {quot_r[NW-2:0], rem_ge};
        if (cnt_r == '0) begin
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_MUL: begin
        period_nxt = (mul_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : mul_ext[31:0];
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and the period are reset; working registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      period_r <= RST_PERIOD;
    end else begin
      state_r  <= state_nxt;
      period_r <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tempo_r <= tempo_nxt;
    bpm_r   <= bpm_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign busy   = (state_r != ST_IDLE);
  assign period = period_r;

endmodule : tcd_period_div

`default_nettype wire

// File: rtl/tempo_clock_divider.sv
// Top level of the tempo clock divider: tick pipeline, mode register and period unit.
//
// Each accepted item is one timer tick and yields exactly one result item. The block
// takes one item per clock cycle while the period unit is idle and the output is not
// stalled; an item is held in an input register, evaluated against the pulse state in
// one pass, and its result is loaded into the output register once that register is
// free. Writing the tempo register starts the bit-serial period divider, which takes one
// quotient bit a cycle for NW-bit dividends; NW = clog2(120000000 / PULSES_PER_QUARTER + 1)
// is 21 at the default. While busy, no item and no further configuration write is taken.
// Writing the mode register does not make the period unit busy.
`default_nettype none

module tempo_clock_divider
  import tcd_pkg::*;
#(
  parameter int PULSES_PER_QUARTER = PULSES_PER_QUARTER_DEF,
  parameter int CLOCK_DIVIDE       = CLOCK_DIVIDE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tcd_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tcd_out_t                   out_data
);

  // Phase counter width and its thresholds.
  localparam int PW = $clog2(CLOCK_DIVIDE + 1);
  localparam logic [PW-1:0] PH_FULL  = PW'(CLOCK_DIVIDE);
  localparam logic [PW-1:0] PH_HALF  = PW'(CLOCK_DIVIDE / 2);
  localparam logic [PW-1:0] PH_LATE  = PW'(15 * CLOCK_DIVIDE / 16);
  localparam logic [PW-1:0] PH_EARLY = PW'(7 * CLOCK_DIVIDE / 16);

  logic              per_busy;
  logic [31:0]       period;
  logic              cfg_fire;
  logic              in_fire;
  logic              advance;

  logic [MODE_W-1:0] mode_r;
  logic              s1_valid_r;
  tcd_in_t           s1_data_r;
  logic              out_valid_r;
  tcd_out_t          out_data_r, out_data_nxt;

  logic [PW-1:0]     phase_r, phase_nxt;
  logic [31:0]       last_r, last_nxt;
  logic              clk_out_r, clk_out_nxt;
  logic              load_ok_r, load_ok_nxt;
  logic [31:0]       elapsed;
  logic              tick;
  logic              pulse;

  // Configuration writes wait while the period unit works.
  assign cfg_ready = !per_busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  tcd_period_div #(
    .PULSES_PER_QUARTER(PULSES_PER_QUARTER)
  ) u_period (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_fire && (cfg_index == REG_TEMPO)),
    .tempo (cfg_data[TEMPO_W-1:0]),
    .busy  (per_busy),
    .period(period)
  );

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INTERNAL;
    end else if (cfg_fire && (cfg_index == REG_MODE)) begin
      mode_r <= cfg_data[MODE_W-1:0];
    end
  end

  // Pipeline flow: the input stage moves on whenever the output register is free.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !per_busy && (!s1_valid_r || advance);
  assign in_fire  = in_valid && in_ready;

  // Per-tick evaluation of the pulse, phase and load-permit state.
  assign elapsed = s1_data_r.cycle_time - last_r;

  always_comb begin
    phase_nxt   = phase_r;
    last_nxt    = last_r;
    clk_out_nxt = clk_out_r;
    load_ok_nxt = load_ok_r;
    tick        = 1'b0;
    pulse       = 1'b0;
    unique case (mode_r)
      MODE_INTERNAL: begin
        if (phase_nxt > PH_HALF) begin
          load_ok_nxt = 1'b0;
        end
        if (elapsed > period) begin
          if (phase_nxt < PH_FULL) begin
            phase_nxt = phase_nxt + PW'(1);
          end
          if ((phase_nxt >= PH_FULL) && s1_data_r.playing) begin
            clk_out_nxt = 1'b1;
            load_ok_nxt = 1'b1;
            tick        = 1'b1;
            phase_nxt   = '0;
          end
          pulse    = 1'b1;
          last_nxt = last_r + period;
        end
        // Loading is blocked in the windows just before each clock edge.
        if ((phase_nxt >= PH_LATE) && (phase_nxt < PH_FULL)) begin
          load_ok_nxt = 1'b0;
        end
        if ((phase_nxt >= PH_EARLY) && (phase_nxt < PH_HALF)) begin
          load_ok_nxt = 1'b0;
        end
        if ((phase_nxt >= PH_HALF) && clk_out_nxt) begin
          clk_out_nxt = 1'b0;
          load_ok_nxt = 1'b1;
        end
      end
      MODE_MIDI: begin
        load_ok_nxt = 1'b1;
        clk_out_nxt = s1_data_r.midi_clock_level;
      end
      default: begin
        load_ok_nxt = 1'b1;
      end
    endcase
    out_data_nxt.clock_level     = clk_out_nxt;
    out_data_nxt.midi_clock_tick = tick;
    out_data_nxt.ppq_pulse       = pulse;
    out_data_nxt.load_permit     = load_ok_nxt;
  end

  // Control and tick state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      last_r      <= '0;
      clk_out_r   <= 1'b0;
      load_ok_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        last_r      <= last_nxt;
        clk_out_r   <= clk_out_nxt;
        load_ok_r   <= load_ok_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A clock tick message always goes out with the clock raised.
  a_tick_raises_clock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.midi_clock_tick || out_data.clock_level))
    else $error("MIDI clock tick without raised clock level");

  // External modes never produce pulses or ticks.
  a_ext_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (mode_r != MODE_INTERNAL)) |=>
      (!out_data.ppq_pulse && !out_data.midi_clock_tick))
    else $error("pulse or tick produced in an external clock mode");

  // The phase saturates at the divider length.
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_FULL)
    else $error("pulse phase beyond the divider length");

  // A tempo write starts the period unit.
  a_tempo_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_fire && (cfg_index == REG_TEMPO)) |=> per_busy)
    else $error("tempo write did not start the period unit");

  // No tick is taken while the period is being recomputed.
  a_no_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
    per_busy |=> !$rose(s1_valid_r))
    else $error("item taken while the period unit was busy");

endmodule : tempo_clock_divider

`default_nettype wire
